### rtl/udp_command_packet_deframer_core_assert.svh
// Assertion macros shared by the deframer modules.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef UDP_COMMAND_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define UDP_COMMAND_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define UCPD_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define UCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ucpd_pkg.sv
// ----------------------------------------------------------------------------
// ucpd_pkg
// Types and constants shared by the datagram command deframer modules.
// ----------------------------------------------------------------------------
package ucpd_pkg;

  localparam int SIG_BYTES     = 4;
  localparam int HDR_BYTES     = 4;
  localparam int MIN_PKT_BYTES = 8;
  localparam int OFFSET_W      = 11;
  localparam int REMAIN_W      = 10;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CMDS  = 1'd1;

  localparam logic [31:0] SIGNATURE_RESET = 32'h4D49_4449;
  localparam logic [7:0]  MAX_CMDS_RESET  = 8'd255;

  // Result kinds
  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_END = 1'b1;

  // End-of-datagram status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_SIG   = 3'd2;
  localparam logic [2:0] ST_TRUNC_HDR = 3'd3;
  localparam logic [2:0] ST_TRUNC_PAY = 3'd4;
  localparam logic [2:0] ST_LIMIT     = 3'd5;
  localparam logic [2:0] ST_OVERSIZE  = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [7:0]          command_code;
    logic [7:0]          payload_word_count;
    logic [7:0]          specific_one;
    logic [7:0]          specific_two;
    logic [OFFSET_W-1:0] payload_offset;
    logic [2:0]          status;
    logic [7:0]          command_count;
    logic                out_last;
  } out_item_t;

  // Results produced by one byte: a descriptor, a summary, or both in order
  typedef struct packed {
    logic      desc_en;
    logic      sum_en;
    out_item_t desc;
    out_item_t sum;
  } res_pair_t;

endpackage

### rtl/ucpd_parser.sv
// ----------------------------------------------------------------------------
// ucpd_parser
// Per-datagram parse state and the single-pass byte step that produces the
// command descriptor and end summary for the byte in the input register.
// ----------------------------------------------------------------------------
module ucpd_parser #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  ucpd_pkg::in_item_t item,
  input  logic [31:0]        expected_signature,
  input  logic [7:0]         max_commands,
  output ucpd_pkg::res_pair_t res
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int EXT_W = (POS_W + 1 > ucpd_pkg::OFFSET_W) ? POS_W + 1 : ucpd_pkg::OFFSET_W;

  typedef enum logic [1:0] {PH_SIG, PH_HDR, PH_PAY, PH_STOP} phase_t;

  phase_t                         phase, phase_next;
  logic [POS_W-1:0]               pos, pos_next;
  logic [31:0]                    shf, shf_next;
  logic [ucpd_pkg::OFFSET_W-1:0]  hold, hold_next;
  logic [ucpd_pkg::REMAIN_W-1:0]  rem, rem_next;
  logic [7:0]                     cnt, cnt_next;
  logic [2:0]                     why, why_next;

  logic [31:0]                    hdr_word;
  logic [31:0]                    cur_hdr;
  logic [EXT_W-1:0]               pos_ext;
  logic [ucpd_pkg::OFFSET_W-1:0]  cur_hold;
  logic [ucpd_pkg::REMAIN_W-1:0]  rem_step;
  logic                           start_hdr;
  logic                           desc_fire;
  logic [2:0]                     sum_status;
  logic [7:0]                     sum_count;

  assign hdr_word = {shf[23:0], item.data_byte};
  assign pos_ext  = EXT_W'(pos) + EXT_W'(1);
  assign cur_hdr  = (phase == PH_HDR) ? hdr_word : shf;
  assign cur_hold = (phase == PH_HDR) ? pos_ext[ucpd_pkg::OFFSET_W-1:0] : hold;

  // Step the parse state by one byte
  always_comb begin
    phase_next  = phase;
    shf_next    = shf;
    hold_next   = hold;
    rem_next    = rem;
    cnt_next    = cnt;
    why_next    = why;
    start_hdr   = 1'b0;
    desc_fire   = 1'b0;
    rem_step    = '0;

    if (phase == PH_STOP) begin
      if (why == ucpd_pkg::ST_OK) begin
        why_next = ucpd_pkg::ST_LIMIT;
      end
    end else if (pos >= POS_W'(MAX_PACKET_BYTES)) begin
      why_next   = ucpd_pkg::ST_OVERSIZE;
      phase_next = PH_STOP;
    end else if (phase == PH_SIG) begin
      shf_next = hdr_word;
      if (pos >= POS_W'(ucpd_pkg::SIG_BYTES - 1)) begin
        if (hdr_word != expected_signature) begin
          phase_next = PH_STOP;
          why_next   = ucpd_pkg::ST_BAD_SIG;
        end else begin
          start_hdr = 1'b1;
        end
      end
    end else if (phase == PH_HDR) begin
      shf_next = hdr_word;
      rem_step = rem + ucpd_pkg::REMAIN_W'(1);
      rem_next = rem_step;
      if (rem_step >= ucpd_pkg::REMAIN_W'(ucpd_pkg::HDR_BYTES)) begin
        hold_next = cur_hold;
        if (hdr_word[23:16] == 8'd0) begin
          desc_fire = 1'b1;
          cnt_next  = cnt + 8'd1;
          start_hdr = 1'b1;
        end else begin
          phase_next = PH_PAY;
          rem_next   = {hdr_word[23:16], 2'b00};
        end
      end
    end else begin
      rem_step = (rem != '0) ? rem - ucpd_pkg::REMAIN_W'(1) : rem;
      rem_next = rem_step;
      if (rem_step == '0) begin
        desc_fire = 1'b1;
        cnt_next  = cnt + 8'd1;
        start_hdr = 1'b1;
      end
    end

    // Open the next command header unless the limit is reached
    if (start_hdr) begin
      if (cnt_next >= max_commands) begin
        phase_next = PH_STOP;
      end else begin
        phase_next = PH_HDR;
        rem_next   = '0;
        shf_next   = '0;
      end
    end

    pos_next = (pos < POS_W'(MAX_PACKET_BYTES)) ? pos + POS_W'(1) : pos;
  end

  // Rank the end status
  always_comb begin
    sum_count = cnt_next;
    if (pos_next < POS_W'(ucpd_pkg::MIN_PKT_BYTES)) begin
      sum_status = ucpd_pkg::ST_TOO_SHORT;
      sum_count  = '0;
    end else if (why_next != ucpd_pkg::ST_OK) begin
      sum_status = why_next;
    end else if (phase_next == PH_HDR && rem_next != '0) begin
      sum_status = ucpd_pkg::ST_TRUNC_HDR;
    end else if (phase_next == PH_PAY) begin
      sum_status = ucpd_pkg::ST_TRUNC_PAY;
    end else if (phase_next == PH_SIG) begin
      sum_status = ucpd_pkg::ST_TOO_SHORT;
      sum_count  = '0;
    end else begin
      sum_status = ucpd_pkg::ST_OK;
    end
  end

  // Build the result items
  always_comb begin
    res.desc_en                 = desc_fire;
    res.sum_en                  = item.in_last;
    res.desc                    = '0;
    res.desc.kind               = ucpd_pkg::KIND_CMD;
    res.desc.command_code       = cur_hdr[31:24];
    res.desc.payload_word_count = cur_hdr[23:16];
    res.desc.specific_one       = cur_hdr[15:8];
    res.desc.specific_two       = cur_hdr[7:0];
    res.desc.payload_offset     = cur_hold;
    res.sum                     = '0;
    res.sum.kind                = ucpd_pkg::KIND_END;
    res.sum.status              = sum_status;
    res.sum.command_count       = sum_count;
    res.sum.out_last            = 1'b1;
  end

  // Hold parse state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst || (fire && item.in_last)) begin
      phase <= PH_SIG;
      pos   <= '0;
      shf   <= '0;
      hold  <= '0;
      rem   <= '0;
      cnt   <= '0;
      why   <= ucpd_pkg::ST_OK;
    end else if (fire) begin
      phase <= phase_next;
      pos   <= pos_next;
      shf   <= shf_next;
      hold  <= hold_next;
      rem   <= rem_next;
      cnt   <= cnt_next;
      why   <= why_next;
    end
  end

`include "udp_command_packet_deframer_core_assert.svh"

  `UCPD_ASSERT_NEXT(a_clear_after_last, fire && item.in_last, pos == '0 && phase == PH_SIG && cnt == '0, "parse state not cleared after last byte")
  `UCPD_ASSERT_HOLDS(a_early_stop_reason, phase != PH_STOP || why == ucpd_pkg::ST_OK || why == ucpd_pkg::ST_BAD_SIG || why == ucpd_pkg::ST_LIMIT || why == ucpd_pkg::ST_OVERSIZE, "stopped with an impossible reason")

endmodule

### rtl/ucpd_outq.sv
// ----------------------------------------------------------------------------
// ucpd_outq
// Two-entry result queue. Takes up to two results from one byte in order and
// drives the output channel from its head entry.
// ----------------------------------------------------------------------------
module ucpd_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  ucpd_pkg::res_pair_t res,
  output logic [1:0]          room,
  output logic                out_valid,
  input  logic                out_ready,
  output ucpd_pkg::out_item_t out_item
);

  logic [1:0]          count, count_next;
  logic [1:0]          count_left;
  logic [1:0]          n_push;
  logic                pop;
  ucpd_pkg::out_item_t r0, r0_next;
  ucpd_pkg::out_item_t r1, r1_next;
  ucpd_pkg::out_item_t base0;
  ucpd_pkg::out_item_t first;

  assign pop       = out_valid && out_ready;
  assign room      = 2'd2 - count;
  assign out_valid = (count != 2'd0);
  assign out_item  = r0;

  // Shift on pop, then append the new results behind what is left
  always_comb begin
    n_push     = fire ? ({1'b0, res.desc_en} + {1'b0, res.sum_en}) : 2'd0;
    count_left = pop ? count - 2'd1 : count;
    base0      = pop ? r1 : r0;
    first      = res.desc_en ? res.desc : res.sum;
    r0_next    = base0;
    r1_next    = r1;
    case (count_left)
      2'd0: begin
        r0_next = first;
        r1_next = res.sum;
      end
      2'd1: begin
        r1_next = first;
      end
      default: begin
      end
    endcase
    count_next = count_left + n_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    r0 <= r0_next;
    r1 <= r1_next;
  end

`include "udp_command_packet_deframer_core_assert.svh"

  `UCPD_ASSERT_HOLDS(a_no_overflow, count_left + n_push <= 2'd2, "result queue overflow")

endmodule

### rtl/udp_command_packet_deframer_core.sv
// Datagram command deframer. Bytes enter one per clock while the result
// queue has room, and each byte is processed while it is held in the input
// register; the sustained rate is one byte per clock unless results back up.
// A byte that ends a command or the datagram places its results in a
// two-entry result queue, and a byte waits in the input register only while
// that queue lacks room for the results it makes (the last byte that
// completes a command yields a descriptor and a summary). Bytes that make no
// result flow through even while the output is stalled. No clearing pass
// follows reset. Configuration writes are taken at once and must come while
// the block is idle.
// ----------------------------------------------------------------------------
// udp_command_packet_deframer_core
// Top level: input register, configuration registers, parser and result queue.
// ----------------------------------------------------------------------------
module udp_command_packet_deframer_core #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ucpd_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ucpd_pkg::out_item_t                 out_item,
  input  logic                                cfg_wr_en,
  input  logic [ucpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ucpd_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  logic                in_v;
  ucpd_pkg::in_item_t  in_q;
  logic [31:0]         expected_signature;
  logic [7:0]          max_commands;
  ucpd_pkg::res_pair_t res;
  logic [1:0]          room;
  logic [1:0]          n_res;
  logic                fire;

  // Process the held byte when the queue can take all its results
  assign n_res    = {1'b0, res.desc_en} + {1'b0, res.sum_en};
  assign fire     = in_v && (n_res <= room);
  assign in_ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ready) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_signature <= ucpd_pkg::SIGNATURE_RESET;
      max_commands       <= ucpd_pkg::MAX_CMDS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ucpd_pkg::CFG_SIGNATURE: expected_signature <= cfg_wr_data[31:0];
        ucpd_pkg::CFG_MAX_CMDS:  max_commands       <= cfg_wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ucpd_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .item               (in_q),
    .expected_signature (expected_signature),
    .max_commands       (max_commands),
    .res                (res)
  );

  ucpd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`include "udp_command_packet_deframer_core_assert.svh"

  `UCPD_ASSERT_HOLDS(a_summary_marks_last, !out_valid || (out_item.kind == out_item.out_last), "out_last does not match result kind")
  `UCPD_ASSERT_HOLDS(a_desc_clean, !out_valid || out_item.kind == ucpd_pkg::KIND_END || (out_item.status == ucpd_pkg::ST_OK && out_item.command_count == 8'd0), "descriptor carries summary fields")

endmodule

### test/udp_command_packet_deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_command_packet_deframer_checker
// Watches the byte, result and configuration ports of the deframer. It keeps
// its own parse of every datagram and compares each result with the oldest
// one still awaited.
// ----------------------------------------------------------------------------
module udp_command_packet_deframer_checker #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  ucpd_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  ucpd_pkg::out_item_t             out_item,
  input  logic                            cfg_wr_en,
  input  logic [ucpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ucpd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output int                              fail_count,
  output int                              pending
);
  import ucpd_pkg::*;

  localparam int WORD_BYTES = 4;

  typedef enum logic [1:0] {SCAN_SIG, SCAN_HDR, SCAN_PAY, SCAN_STOP} scan_phase_t;

  // Configuration copy
  logic [31:0] want_sig;
  logic [7:0]  cmd_limit;

  // Parse state of the current datagram
  int unsigned byte_pos;
  logic [31:0] hdr_shift;
  scan_phase_t phase;
  int unsigned payload_start;
  int unsigned left_count;
  logic [7:0]  cmds_found;
  logic [2:0]  early_status;

  // Descriptors and summaries not yet seen on the output
  out_item_t awaited_records[$];

  function automatic void clear_packet();
    byte_pos      = 0;
    hdr_shift     = '0;
    phase         = SCAN_SIG;
    payload_start = 0;
    left_count    = 0;
    cmds_found    = '0;
    early_status  = ST_OK;
  endfunction

  // Start the next header, or stop once the command limit is reached
  function automatic void open_header();
    if (cmds_found >= cmd_limit) begin
      phase = SCAN_STOP;
    end else begin
      phase      = SCAN_HDR;
      left_count = 0;
      hdr_shift  = '0;
    end
  endfunction

  function automatic void close_command();
    out_item_t rec;
    rec                    = '0;
    rec.kind               = KIND_CMD;
    rec.command_code       = hdr_shift[31:24];
    rec.payload_word_count = hdr_shift[23:16];
    rec.specific_one       = hdr_shift[15:8];
    rec.specific_two       = hdr_shift[7:0];
    rec.payload_offset     = payload_start[OFFSET_W-1:0];
    awaited_records.push_back(rec);
    cmds_found = cmds_found + 8'd1;
    open_header();
  endfunction

  // Advance the parse by one accepted byte and queue what it produces
  function automatic void parse_byte(in_item_t req);
    int unsigned at;
    out_item_t   summary;
    at = byte_pos;
    if (phase == SCAN_STOP) begin
      if (early_status == ST_OK) begin
        early_status = ST_LIMIT;
      end
    end else if (at >= MAX_PACKET_BYTES) begin
      early_status = ST_OVERSIZE;
      phase        = SCAN_STOP;
    end else if (phase == SCAN_SIG) begin
      hdr_shift = {hdr_shift[23:0], req.data_byte};
      if (at >= SIG_BYTES - 1) begin
        if (hdr_shift != want_sig) begin
          phase        = SCAN_STOP;
          early_status = ST_BAD_SIG;
        end else begin
          open_header();
        end
      end
    end else if (phase == SCAN_HDR) begin
      hdr_shift  = {hdr_shift[23:0], req.data_byte};
      left_count = left_count + 1;
      if (left_count >= HDR_BYTES) begin
        payload_start = at + 1;
        if (hdr_shift[23:16] == 8'd0) begin
          close_command();
        end else begin
          phase      = SCAN_PAY;
          left_count = WORD_BYTES * int'(hdr_shift[23:16]);
        end
      end
    end else begin
      if (left_count > 0) begin
        left_count = left_count - 1;
      end
      if (left_count == 0) begin
        close_command();
      end
    end

    if (at < MAX_PACKET_BYTES) begin
      byte_pos = at + 1;
    end

    // Close the datagram with its summary
    if (req.in_last) begin
      summary               = '0;
      summary.kind          = KIND_END;
      summary.out_last      = 1'b1;
      summary.command_count = cmds_found;
      if (byte_pos < MIN_PKT_BYTES) begin
        summary.status        = ST_TOO_SHORT;
        summary.command_count = '0;
      end else if (early_status != ST_OK) begin
        summary.status = early_status;
      end else if (phase == SCAN_HDR && left_count != 0) begin
        summary.status = ST_TRUNC_HDR;
      end else if (phase == SCAN_PAY) begin
        summary.status = ST_TRUNC_PAY;
      end else if (phase == SCAN_SIG) begin
        summary.status        = ST_TOO_SHORT;
        summary.command_count = '0;
      end else begin
        summary.status = ST_OK;
      end
      awaited_records.push_back(summary);
      clear_packet();
    end
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    want = awaited_records.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("command_code", want.command_code, got.command_code);
    check_field("payload_word_count", want.payload_word_count, got.payload_word_count);
    check_field("specific_one", want.specific_one, got.specific_one);
    check_field("specific_two", want.specific_two, got.specific_two);
    check_field("payload_offset", want.payload_offset, got.payload_offset);
    check_field("status", want.status, got.status);
    check_field("command_count", want.command_count, got.command_count);
    check_field("out_last", want.out_last, got.out_last);
  endfunction

  // Track configuration, parse requests and compare results at each edge
  always @(posedge clk) begin
    if (rst) begin
      want_sig  = SIGNATURE_RESET;
      cmd_limit = MAX_CMDS_RESET;
      clear_packet();
      awaited_records.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SIGNATURE) begin
          want_sig = cfg_wr_data;
        end else if (cfg_index == CFG_MAX_CMDS) begin
          cmd_limit = cfg_wr_data[7:0];
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_item);
      end
      if (out_valid && out_ready) begin
        if (awaited_records.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_item);
          fail_count++;
        end else begin
          check_result(out_item);
        end
      end
    end
    pending = awaited_records.size();
  end

endmodule

### test/udp_command_packet_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_command_packet_deframer_core_tb
// Feeds datagrams byte by byte into the deframer: a few hand-built packets,
// then mostly well-formed random datagrams with broken and noisy ones mixed
// in, under several signature and command-limit settings, and finally a
// packet that runs on past its command limit. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module udp_command_packet_deframer_core_tb;
  import ucpd_pkg::*;

  localparam int PKT_BYTES    = 2048;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int END_CYCLES   = 20;

  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_item_t              in_item     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  out_item_t             out_item;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_SIGNATURE;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  int          mode_left   = 0;
  ready_mode_t ready_mode  = RDY_ALWAYS;
  logic [31:0] cur_sig     = SIGNATURE_RESET;
  logic [7:0]  datagram[$];

  udp_command_packet_deframer_core #(
    .MAX_PACKET_BYTES(PKT_BYTES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  udp_command_packet_deframer_checker #(
    .MAX_PACKET_BYTES(PKT_BYTES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side in stretches of changing character
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(8, 80);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_HALF:   out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:    out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one byte, hold it until taken, then maybe pause between bursts
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int gap;
    in_valid <= 1'b1;
    in_item  <= '{data_byte: value, in_last: is_last};
    @(negedge clk);
    while (!in_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_datagram();
    for (int i = 0; i < datagram.size(); i++) begin
      send_byte(datagram[i], i == datagram.size() - 1);
    end
  endtask

  function automatic void push_word(logic [31:0] w);
    datagram.push_back(w[31:24]);
    datagram.push_back(w[23:16]);
    datagram.push_back(w[15:8]);
    datagram.push_back(w[7:0]);
  endfunction

  // Append a header and a payload of random bytes
  function automatic void push_command(logic [7:0] code, int words, logic [7:0] s1,
                                       logic [7:0] s2);
    push_word({code, 8'(words), s1, s2});
    repeat (4 * words) datagram.push_back(8'($urandom));
  endfunction

  function automatic void push_noise(int count);
    repeat (count) datagram.push_back(8'($urandom));
  endfunction

  // Build one random datagram, mostly well formed
  function automatic void build_random_datagram();
    int pick;
    int tail;
    int words;
    int cut;
    datagram.delete();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      push_word(cur_sig);
      repeat ($urandom_range(0, 5)) begin
        words = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 2);
        push_command(8'($urandom), words, 8'($urandom), 8'($urandom));
      end
      tail = $urandom_range(0, 99);
      if (tail < 30) begin
        // cut into the last command or the signature
        cut = $urandom_range(1, 6);
        while (cut > 0 && datagram.size() > 1) begin
          void'(datagram.pop_back());
          cut--;
        end
      end else if (tail < 55) begin
        push_noise($urandom_range(1, 3));
      end else if (tail < 75) begin
        push_noise($urandom_range(4, 12));
      end
    end else if (pick < 80) begin
      push_word(cur_sig ^ (32'h1 << $urandom_range(0, 31)));
      push_noise($urandom_range(0, 12));
    end else if (pick < 90) begin
      push_word(cur_sig);
      push_noise(3);
      cut = $urandom_range(1, 7);
      while (datagram.size() > cut) begin
        void'(datagram.pop_back());
      end
    end else begin
      push_noise($urandom_range(1, 24));
    end
  endfunction

  task automatic run_random(input int byte_goal);
    int sent;
    sent = 0;
    while (sent < byte_goal) begin
      build_random_datagram();
      sent += datagram.size();
      send_datagram();
    end
  endtask

  // Drop valid, wait for every awaited result, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] sig, input logic [7:0] limit);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_SIGNATURE;
    cfg_wr_data <= sig;
    @(posedge clk);
    cfg_index   <= CFG_MAX_CMDS;
    cfg_wr_data <= {24'd0, limit};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_sig = sig;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Hand-built packets under the reset configuration
    datagram = {8'hFF};
    send_datagram();
    datagram = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_datagram();
    datagram.delete();
    push_word(cur_sig);
    push_command(8'hFF, 0, 8'hFF, 8'hFF);
    send_datagram();
    datagram.delete();
    push_word(cur_sig);
    push_word(32'h0001_0000);
    datagram.push_back(8'hAA);
    datagram.push_back(8'h55);
    send_datagram();

    // One command allowed: extra bytes hit the limit
    wait_drained();
    set_config(SIGNATURE_RESET, 8'd1);
    datagram.delete();
    push_word(cur_sig);
    push_command(8'h12, 0, 8'h34, 8'h56);
    datagram.push_back(8'h77);
    datagram.push_back(8'h88);
    send_datagram();
    run_random(50);

    wait_drained();
    set_config($urandom, 8'd255);
    run_random(120);

    wait_drained();
    set_config(32'h0000_0000, 8'd3);
    run_random(80);

    wait_drained();
    set_config(32'hFFFF_FFFF, 8'd2);
    run_random(80);

    // Limit reached early, then more bytes follow
    wait_drained();
    set_config($urandom, 8'd1);
    datagram.delete();
    push_word(cur_sig);
    push_command(8'($urandom), 0, 8'($urandom), 8'($urandom));
    push_noise(6);
    send_datagram();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### udp_command_packet_deframer_core.f
+incdir+rtl
rtl/ucpd_pkg.sv
rtl/ucpd_parser.sv
rtl/ucpd_outq.sv
rtl/udp_command_packet_deframer_core.sv
test/udp_command_packet_deframer_checker.sv
test/udp_command_packet_deframer_core_tb.sv
